// ===== hw/rtl/dltq_pkg.sv =====
// dltq_pkg: shared types and codes for the delta-list timer queue.
// Depends on nothing; used by delta_list_timer_queue_unit and tb_top.
package dltq_pkg;

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;
    localparam logic [1:0] MODE_CLEAR    = 2'd3;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    localparam int ID_BITS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_INS_GO,
        ST_INS_RD,
        ST_INS_EV,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_TK_RD,
        ST_TK_EV,
        ST_NX_RD,
        ST_NX_EV,
        ST_EMIT,
        ST_DN_RD,
        ST_DN_WR
    } state_t;

endpackage

// ===== hw/rtl/delta_list_timer_queue_unit.sv =====
// Delta-list timer queue. Each transaction is a tick (mode 0), a one-shot add (1), a
// periodic add (2) or a clear (3). Timers sit in one RAM in expiry order, each holding
// the time left after the one in front. Items are handled one at a time. An add walks the
// list, reading and checking each entry, and then shifts the tail up one entry at a time,
// reading and writing each one. Each timer a tick fires costs a head read, a result and a
// shift down of the rest of the list; a fired interval adds one insert. A clear, or a tick
// on an empty queue, is done from the idle state; a tick with nothing due reads the head,
// writes back its reduced delta and returns to idle. A full queue answers an add with a
// reject result.
// Depends on dltq_pkg and dltq_ram.
module delta_list_timer_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_amount,
    input  logic [7:0]  s_timer_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_fired_id,
    output logic        m_last
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = TIME_BITS + 1;
    localparam int RW = TIME_BITS + 2;
    localparam int IDB = dltq_pkg::ID_BITS;
    localparam int WW = IDB + DW + TIME_BITS + 1;
    localparam int DLO = IDB;
    localparam int PLO = IDB + DW;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);

    dltq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [TIME_BITS-1:0]    want_reg, want_next;
    logic [TIME_BITS-1:0]    amt_reg, amt_next;
    logic [IDB-1:0]          id_reg, id_next;
    logic                    rep_reg, rep_next;
    logic signed [RW-1:0]    run_reg, run_next;
    logic signed [DW-1:0]    nd_reg, nd_next;
    logic signed [DW-1:0]    diff_reg, diff_next;
    logic                    first_reg, first_next;
    logic                    last_reg, last_next;
    logic                    ivl_reg, ivl_next;
    logic                    mv_reg, mv_next;
    logic                    mk_reg, mk_next;
    logic [IDB-1:0]          mid_reg, mid_next;
    logic                    ml_reg, ml_next;

    logic                    we;
    logic [IW-1:0]           waddr, raddr;
    logic [WW-1:0]           wdata, rdata;

    logic [TIME_BITS+31:0]   amt_wide;
    logic signed [DW-1:0]    rd_delta;
    logic signed [RW-1:0]    rd_delta_x, want_x, sum_x, hd_x, nd_x;
    logic                    out_free;

    dltq_ram #(.WIDTH(WW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign amt_wide   = {{TIME_BITS{1'b0}}, s_amount};
    assign rd_delta   = rdata[DLO +: DW];
    assign rd_delta_x = RW'(rd_delta);
    assign want_x     = {2'b00, want_reg};
    assign sum_x      = run_reg + rd_delta_x;
    assign hd_x       = rd_delta_x - (first_reg ? {2'b00, amt_reg} : RW'(0));
    assign nd_x       = rd_delta_x + RW'(diff_reg);
    assign out_free   = !mv_reg || m_ready;

    assign s_ready    = (state_reg == dltq_pkg::ST_IDLE);
    assign m_valid    = mv_reg;
    assign m_kind     = mk_reg;
    assign m_fired_id = mid_reg;
    assign m_last     = ml_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dltq_pkg::ST_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        want_reg  <= want_next;
        amt_reg   <= amt_next;
        id_reg    <= id_next;
        rep_reg   <= rep_next;
        run_reg   <= run_next;
        nd_reg    <= nd_next;
        diff_reg  <= diff_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        ivl_reg   <= ivl_next;
        mk_reg    <= mk_next;
        mid_reg   <= mid_next;
        ml_reg    <= ml_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        want_next  = want_reg;
        amt_next   = amt_reg;
        id_next    = id_reg;
        rep_next   = rep_reg;
        run_next   = run_reg;
        nd_next    = nd_reg;
        diff_next  = diff_reg;
        first_next = first_reg;
        last_next  = last_reg;
        ivl_next   = ivl_reg;
        mv_next    = mv_reg && !m_ready;
        mk_next    = mk_reg;
        mid_next   = mid_reg;
        ml_next    = ml_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rdata;
        raddr      = '0;

        case (state_reg)
            dltq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    id_next    = s_timer_id;
                    want_next  = amt_wide[TIME_BITS-1:0];
                    amt_next   = amt_wide[TIME_BITS-1:0];
                    rep_next   = (s_mode == dltq_pkg::MODE_PERIODIC);
                    first_next = 1'b1;
                    case (s_mode)
                        dltq_pkg::MODE_CLEAR: begin
                            count_next = '0;
                        end
                        dltq_pkg::MODE_TICK: begin
                            if (count_reg != '0) begin
                                state_next = dltq_pkg::ST_TK_RD;
                            end
                        end
                        default: begin
                            if (count_reg == FULL) begin
                                state_next = dltq_pkg::ST_REJECT;
                            end else begin
                                state_next = dltq_pkg::ST_INS_GO;
                            end
                        end
                    endcase
                end
            end
            dltq_pkg::ST_REJECT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = dltq_pkg::KIND_REJECT;
                    mid_next   = id_reg;
                    ml_next    = 1'b1;
                    state_next = dltq_pkg::ST_IDLE;
                end
            end
            dltq_pkg::ST_INS_GO: begin
                idx_next = '0;
                run_next = '0;
                if (count_reg == '0) begin
                    pos_next   = '0;
                    nd_next    = DW'(want_x);
                    state_next = dltq_pkg::ST_INS_WR;
                end else begin
                    state_next = dltq_pkg::ST_INS_RD;
                end
            end
            dltq_pkg::ST_INS_RD: begin
                raddr      = idx_reg[IW-1:0];
                state_next = dltq_pkg::ST_INS_EV;
            end
            dltq_pkg::ST_INS_EV: begin
                if (want_x <= sum_x) begin
                    // found the slot: open a hole by shifting the tail up
                    pos_next   = idx_reg;
                    nd_next    = DW'(want_x - run_reg);
                    idx_next   = count_reg;
                    state_next = dltq_pkg::ST_SH_RD;
                end else begin
                    run_next = sum_x;
                    idx_next = idx_reg + ONE;
                    if (idx_reg + ONE == count_reg) begin
                        pos_next   = count_reg;
                        nd_next    = DW'(want_x - sum_x);
                        state_next = dltq_pkg::ST_INS_WR;
                    end else begin
                        state_next = dltq_pkg::ST_INS_RD;
                    end
                end
            end
            dltq_pkg::ST_SH_RD: begin
                raddr      = IW'(idx_reg - ONE);
                state_next = dltq_pkg::ST_SH_WR;
            end
            dltq_pkg::ST_SH_WR: begin
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                if (idx_reg == pos_reg + ONE) begin
                    wdata[DLO +: DW] = rd_delta - nd_reg;
                end
                idx_next = idx_reg - ONE;
                if (idx_reg - ONE == pos_reg) begin
                    state_next = dltq_pkg::ST_INS_WR;
                end else begin
                    state_next = dltq_pkg::ST_SH_RD;
                end
            end
            dltq_pkg::ST_INS_WR: begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                wdata      = {rep_reg, want_reg, nd_reg, id_reg};
                count_next = count_reg + ONE;
                state_next = dltq_pkg::ST_IDLE;
            end
            dltq_pkg::ST_TK_RD: begin
                raddr      = '0;
                state_next = dltq_pkg::ST_TK_EV;
            end
            dltq_pkg::ST_TK_EV: begin
                first_next = 1'b0;
                if (hd_x > 0) begin
                    we               = 1'b1;
                    waddr            = '0;
                    wdata[DLO +: DW] = DW'(hd_x);
                    state_next       = dltq_pkg::ST_IDLE;
                end else begin
                    diff_next = DW'(hd_x);
                    id_next   = rdata[IDB-1:0];
                    want_next = rdata[PLO +: TIME_BITS];
                    ivl_next  = rdata[WW-1];
                    if (rdata[WW-1] || count_reg == ONE) begin
                        last_next  = 1'b1;
                        state_next = dltq_pkg::ST_EMIT;
                    end else begin
                        state_next = dltq_pkg::ST_NX_RD;
                    end
                end
            end
            dltq_pkg::ST_NX_RD: begin
                raddr      = IW'(1);
                state_next = dltq_pkg::ST_NX_EV;
            end
            dltq_pkg::ST_NX_EV: begin
                // carry the overshoot into the next timer
                nd_next    = DW'(nd_x);
                last_next  = (nd_x > 0);
                state_next = dltq_pkg::ST_EMIT;
            end
            dltq_pkg::ST_EMIT: begin
                if (out_free) begin
                    mv_next  = 1'b1;
                    mk_next  = dltq_pkg::KIND_FIRED;
                    mid_next = id_reg;
                    ml_next  = last_reg;
                    idx_next = ONE;
                    rep_next = 1'b1;
                    if (count_reg == ONE) begin
                        count_next = '0;
                        state_next = ivl_reg ? dltq_pkg::ST_INS_GO : dltq_pkg::ST_IDLE;
                    end else begin
                        state_next = dltq_pkg::ST_DN_RD;
                    end
                end
            end
            dltq_pkg::ST_DN_RD: begin
                raddr      = idx_reg[IW-1:0];
                state_next = dltq_pkg::ST_DN_WR;
            end
            dltq_pkg::ST_DN_WR: begin
                we    = 1'b1;
                waddr = IW'(idx_reg - ONE);
                if (idx_reg == ONE && !ivl_reg) begin
                    wdata[DLO +: DW] = nd_reg;
                end
                idx_next = idx_reg + ONE;
                if (idx_reg + ONE == count_reg) begin
                    count_next = count_reg - ONE;
                    state_next = ivl_reg ? dltq_pkg::ST_INS_GO : dltq_pkg::ST_TK_RD;
                end else begin
                    state_next = dltq_pkg::ST_DN_RD;
                end
            end
            default: begin
                state_next = dltq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dltq_ram.sv =====
// dltq_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for delta_list_timer_queue_unit.
// Keeps its own delta-list model of the timer queue and scoreboards fire/reject results.
// Depends on dltq_pkg and the RTL of the timer queue.
module tb_top;

    localparam int DEPTH = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [31:0] s_amount;
    logic [7:0]  s_timer_id;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [7:0]  m_fired_id;
    logic        m_last;

    delta_list_timer_queue_unit #(.QUEUE_DEPTH(DEPTH), .TIME_BITS(32)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_amount(s_amount), .s_timer_id(s_timer_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_fired_id(m_fired_id), .m_last(m_last)
    );

    typedef struct packed {
        logic       kind;
        logic [7:0] id;
        logic       last;
    } fire_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] amount;
        logic [7:0]  tid;
        logic        has_exp;
        fire_t       exp;
    } stim_t;

    // Timer list held by the bench
    logic [7:0]        tq_id  [DEPTH+1];
    logic signed [33:0] tq_dlt [DEPTH+1];
    logic [31:0]       tq_per [DEPTH+1];
    logic              tq_rep [DEPTH+1];
    int                tq_used;

    fire_t fires_due[$];
    int    n_bad;
    int    quiet_run;

    function automatic void tq_insert(logic [7:0] id, logic [31:0] dur, logic rep);
        logic signed [33:0] want;
        logic signed [33:0] run;
        logic signed [33:0] nd;
        want = {2'b00, dur};
        run = 0;
        for (int i = 0; i < tq_used; i++) begin
            if (want <= run + tq_dlt[i]) begin
                nd = want - run;
                for (int k = tq_used; k > i; k--) begin
                    tq_id[k] = tq_id[k-1]; tq_dlt[k] = tq_dlt[k-1];
                    tq_per[k] = tq_per[k-1]; tq_rep[k] = tq_rep[k-1];
                end
                tq_id[i] = id; tq_dlt[i] = nd; tq_per[i] = dur; tq_rep[i] = rep;
                tq_used++;
                tq_dlt[i+1] = tq_dlt[i+1] - nd;
                return;
            end
            run = run + tq_dlt[i];
        end
        tq_id[tq_used] = id; tq_dlt[tq_used] = want - run;
        tq_per[tq_used] = dur; tq_rep[tq_used] = rep;
        tq_used++;
    endfunction

    function automatic void tq_pop();
        for (int k = 1; k < tq_used; k++) begin
            tq_id[k-1] = tq_id[k]; tq_dlt[k-1] = tq_dlt[k];
            tq_per[k-1] = tq_per[k]; tq_rep[k-1] = tq_rep[k];
        end
        if (tq_used > 0) tq_used--;
    endfunction

    // Apply one transaction to the list and queue what it should fire
    function automatic void predict_timers(logic [1:0] mode, logic [31:0] amt, logic [7:0] id);
        logic signed [33:0] diff;
        logic [7:0] rid;
        logic [31:0] per;
        int n;
        fire_t f;
        n = 0;
        if (mode == dltq_pkg::MODE_CLEAR) begin
            tq_used = 0;
            return;
        end
        if (mode == dltq_pkg::MODE_ONESHOT || mode == dltq_pkg::MODE_PERIODIC) begin
            if (tq_used >= DEPTH) begin
                f.kind = dltq_pkg::KIND_REJECT; f.id = id; f.last = 1'b1;
                fires_due = {fires_due, f};
            end else begin
                tq_insert(id, amt, mode == dltq_pkg::MODE_PERIODIC);
            end
            return;
        end
        if (tq_used == 0) return;
        tq_dlt[0] = tq_dlt[0] - {2'b00, amt};
        while (tq_used > 0) begin
            diff = tq_dlt[0];
            if (diff > 0) break;
            f.kind = dltq_pkg::KIND_FIRED; f.id = tq_id[0]; f.last = 1'b0;
            fires_due = {fires_due, f};
            n++;
            if (tq_rep[0]) begin
                rid = tq_id[0]; per = tq_per[0];
                tq_pop();
                tq_insert(rid, per, 1'b1);
                break;
            end
            tq_pop();
            if (tq_used == 0) break;
            tq_dlt[0] = tq_dlt[0] + diff;
        end
        if (n > 0) fires_due[fires_due.size()-1].last = 1'b1;
    endfunction

    initial begin
        aclk = 1'b0;
    end
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall except during the quiet stretch
    initial begin
        m_ready = 1'b0;
    end
    always @(posedge aclk) begin
        if (quiet_run > 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) >= 9);
    end

    always @(posedge aclk) begin
        fire_t want;
        if (aresetn && m_valid && m_ready) begin
            if (fires_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result kind=%0d id=%0d last=%0d",
                             m_kind, m_fired_id, m_last);
            end else begin
                want = fires_due.pop_front();
                if (want.kind !== m_kind || want.id !== m_fired_id || want.last !== m_last) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp kind=%0d id=%0d last=%0d, got %0d %0d %0d",
                                 want.kind, want.id, want.last, m_kind, m_fired_id, m_last);
                end
            end
        end
    end

    // Drop valid only while idling, so valid is assigned once per edge
    task automatic send_item(logic [1:0] mode, logic [31:0] amt, logic [7:0] id);
        while (quiet_run == 0 && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_amount <= amt;
        s_timer_id <= id;
        predict_timers(mode, amt, id);
        do @(posedge aclk); while (!s_ready);
        if (quiet_run > 0) quiet_run--;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (fires_due.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        if (fires_due.size() != 0) begin
            $display("RESULT: ERROR");
            $finish;
        end
    endtask

    stim_t dir_rows[$];

    function automatic stim_t row(logic [1:0] m, logic [31:0] a, logic [7:0] t,
                                  logic he, logic k, logic [7:0] fid);
        stim_t r;
        r.mode = m; r.amount = a; r.tid = t; r.has_exp = he;
        r.exp.kind = k; r.exp.id = fid; r.exp.last = 1'b1;
        return r;
    endfunction

    function automatic void put_row(stim_t r);
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        logic [1:0] m;
        logic [31:0] a;
        int sel;
        n_bad = 0;
        quiet_run = 0;
        tq_used = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = dltq_pkg::MODE_TICK;
        s_amount = '0;
        s_timer_id = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty tick, zero-delta head, equal durations, extremes, full queue
        put_row(row(dltq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'h00, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_ONESHOT, 32'd0, 8'hFF, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_TICK, 32'd0, 8'h00, 1, dltq_pkg::KIND_FIRED, 8'hFF));
        put_row(row(dltq_pkg::MODE_ONESHOT, 32'd10, 8'h01, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_ONESHOT, 32'd10, 8'h02, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_ONESHOT, 32'hFFFF_FFFF, 8'h03, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_PERIODIC, 32'd0, 8'h04, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_TICK, 32'd12, 8'h00, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_PERIODIC, 32'd7, 8'hAA, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_TICK, 32'd20, 8'h55, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'h00, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_CLEAR, 32'd0, 8'h00, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_TICK, 32'd5, 8'h00, 0, 0, 0));
        for (int i = 0; i < DEPTH; i++) begin
            if (i % 2 == 0)
                put_row(row(dltq_pkg::MODE_ONESHOT, 32'(3 * i), 8'(16 + i), 0, 0, 0));
            else
                put_row(row(dltq_pkg::MODE_PERIODIC, 32'(5 * i), 8'(16 + i), 0, 0, 0));
        end
        put_row(row(dltq_pkg::MODE_PERIODIC, 32'd1, 8'hC3, 1, dltq_pkg::KIND_REJECT, 8'hC3));
        put_row(row(dltq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'h00, 0, 0, 0));
        put_row(row(dltq_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 8'hFF, 0, 0, 0));

        foreach (dir_rows[i]) begin
            int before_n;
            before_n = fires_due.size();
            send_item(dir_rows[i].mode, dir_rows[i].amount, dir_rows[i].tid);
            // Rows with a typed result must predict exactly that single result
            if (dir_rows[i].has_exp && (fires_due.size() != before_n + 1 ||
                    fires_due[fires_due.size()-1] !== dir_rows[i].exp)) begin
                n_bad++;
                if (n_bad <= 10) $display("table row %0d disagrees with prediction", i);
            end
        end

        // Sender holds until every pending result is back
        wait_drained();

        for (int i = 0; i < 90; i++) begin
            if (i == 30) quiet_run = 30;
            if (i == 60) wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 45) m = dltq_pkg::MODE_TICK;
            else if (sel < 70) m = dltq_pkg::MODE_ONESHOT;
            else if (sel < 96) m = dltq_pkg::MODE_PERIODIC;
            else m = dltq_pkg::MODE_CLEAR;
            sel = $urandom_range(0, 9);
            if (sel < 6) a = $urandom_range(0, 60);
            else if (sel < 8) a = $urandom;
            else a = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 3);
            send_item(m, a, 8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        if (n_bad == 0 && fires_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
